[src/tc_pkg.sv]
// Shared types, codes and constants for the timecode counter.
package tc_pkg;

  // Timecode field limits and drop-frame constants
  localparam logic [5:0] SEC_PER_MIN     = 6'd60;
  localparam logic [5:0] MIN_PER_HOUR    = 6'd60;
  localparam logic [6:0] HOURS_PER_DAY   = 7'd24;
  localparam logic [6:0] HOUR_LIMIT      = 7'd99;
  localparam logic [6:0] LOAD_HOUR_LIMIT = 7'd100;
  localparam logic [5:0] DROP_MIN_PERIOD = 6'd10;
  localparam logic [7:0] DROPPED_FRAMES  = 8'd2;
  localparam logic [7:0] FRAME_COUNT_RST = 8'd30;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FRAME_COUNT = 2'd0,
    REG_DROP_FRAME  = 2'd1,
    REG_WRAP        = 2'd2
  } tc_reg_e;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_FWD  = 2'd0,
    KIND_BACK = 2'd1,
    KIND_LOAD = 2'd2
  } tc_kind_e;

  // Result error codes
  typedef enum logic [2:0] {
    ERR_OK           = 3'd0,
    ERR_HOUR_OVF     = 3'd1,
    ERR_BELOW_ZERO   = 3'd2,
    ERR_LOAD_RANGE   = 3'd3,
    ERR_LOAD_DROPPED = 3'd4
  } tc_err_e;

  typedef struct packed {
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [7:0] frames;
  } tc_time_t;

  typedef struct packed {
    logic [7:0] frame_count;
    logic       drop_frame;
    logic       wrap_day;
  } tc_cfg_t;

endpackage

[src/tc_cfg.sv]
// Configuration registers of the timecode counter.
module tc_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  output tc_pkg::tc_cfg_t     cfg_o
);

  tc_pkg::tc_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Write the addressed register, drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_count <= tc_pkg::FRAME_COUNT_RST;
      cfg_q.drop_frame  <= 1'b0;
      cfg_q.wrap_day    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (tc_pkg::tc_reg_e'(cfg_index_i))
        tc_pkg::REG_FRAME_COUNT: cfg_q.frame_count <= cfg_data_i;
        tc_pkg::REG_DROP_FRAME:  cfg_q.drop_frame  <= cfg_data_i[0];
        tc_pkg::REG_WRAP:        cfg_q.wrap_day    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

[src/tc_step.sv]
// Next-timecode logic: one frame forward, one frame back, or a checked load.
module tc_step (
  input  tc_pkg::tc_cfg_t  cfg_i,
  input  tc_pkg::tc_time_t cur_i,
  input  logic [1:0]       kind_i,
  input  tc_pkg::tc_time_t load_i,
  output tc_pkg::tc_time_t nxt_o,
  output tc_pkg::tc_err_e  err_o
);

  // Hours modulo 24 for a 7-bit value, by repeated subtraction
  function automatic logic [6:0] mod_day(input logic [6:0] v);
    logic [6:0] r;
    r = v;
    for (int i = 0; i < 5; i++) begin
      if (r >= tc_pkg::HOURS_PER_DAY) r = r - tc_pkg::HOURS_PER_DAY;
    end
    return r;
  endfunction

  // Minute that is a multiple of ten
  function automatic logic tenth_minute(input logic [5:0] m);
    return m inside {6'd0, 6'd10, 6'd20, 6'd30, 6'd40, 6'd50, 6'd60};
  endfunction

  // Frame skipped by drop-frame counting
  function automatic logic dropped(input logic df, input logic [5:0] m,
                                   input logic [5:0] s, input logic [7:0] f);
    return df && (s == 6'd0) && (f < tc_pkg::DROPPED_FRAMES) && !tenth_minute(m);
  endfunction

  logic [7:0]       rate;
  tc_pkg::tc_time_t fwd;
  logic             fwd_ovf;
  logic [8:0]       f_inc;
  logic             roll_f;
  logic             roll_s;
  logic             roll_m;
  tc_pkg::tc_time_t bwd;
  logic             below_zero;
  logic [7:0]       f_dec;
  logic             borrow;
  logic [6:0]       ld_hours;
  logic             ld_range_bad;
  logic             ld_dropped;

  // Zero frame count acts as one
  assign rate = (cfg_i.frame_count == 8'd0) ? 8'd1 : cfg_i.frame_count;

  // Forward step: cascade frame, second, minute, hour rollover
  always_comb begin
    fwd     = cur_i;
    fwd_ovf = 1'b0;
    f_inc   = {1'b0, cur_i.frames} + 9'd1;
    roll_f  = f_inc >= {1'b0, rate};
    roll_s  = roll_f && ((cur_i.seconds + 6'd1) >= tc_pkg::SEC_PER_MIN);
    roll_m  = roll_s && ((cur_i.minutes + 6'd1) >= tc_pkg::MIN_PER_HOUR);
    if (roll_f) begin
      fwd.frames  = 8'd0;
      fwd.seconds = roll_s ? 6'd0 : cur_i.seconds + 6'd1;
    end else begin
      fwd.frames = f_inc[7:0];
    end
    if (roll_s) begin
      fwd.minutes = roll_m ? 6'd0 : cur_i.minutes + 6'd1;
    end
    if (roll_m) begin
      if (cfg_i.wrap_day) begin
        fwd.hours = mod_day(cur_i.hours + 7'd1);
      end else if (cur_i.hours < tc_pkg::HOUR_LIMIT) begin
        fwd.hours = cur_i.hours + 7'd1;
      end else begin
        fwd_ovf = 1'b1;
      end
    end
    if (dropped(cfg_i.drop_frame, fwd.minutes, fwd.seconds, fwd.frames)) begin
      fwd.frames = tc_pkg::DROPPED_FRAMES;
    end
  end

  // Backward step: borrow through seconds, minutes and hours
  always_comb begin
    bwd        = cur_i;
    below_zero = !cfg_i.wrap_day && (cur_i == '0);
    f_dec      = cur_i.frames - 8'd1;
    borrow     = (cur_i.frames == 8'd0) ||
                 dropped(cfg_i.drop_frame, cur_i.minutes, cur_i.seconds, f_dec);
    if (borrow) begin
      bwd.frames = rate - 8'd1;
      if (cur_i.seconds == 6'd0) begin
        bwd.seconds = tc_pkg::SEC_PER_MIN - 6'd1;
        if (cur_i.minutes == 6'd0) begin
          bwd.minutes = tc_pkg::MIN_PER_HOUR - 6'd1;
          bwd.hours   = (cur_i.hours == 7'd0) ? tc_pkg::HOURS_PER_DAY - 7'd1
                                              : cur_i.hours - 7'd1;
        end else begin
          bwd.minutes = cur_i.minutes - 6'd1;
        end
      end else begin
        bwd.seconds = cur_i.seconds - 6'd1;
      end
    end else begin
      bwd.frames = f_dec;
    end
  end

  // Load checks
  assign ld_hours     = cfg_i.wrap_day ? mod_day(load_i.hours) : load_i.hours;
  assign ld_range_bad = (ld_hours >= tc_pkg::LOAD_HOUR_LIMIT) ||
                        (load_i.minutes >= tc_pkg::MIN_PER_HOUR) ||
                        (load_i.seconds >= tc_pkg::SEC_PER_MIN) ||
                        (load_i.frames >= rate);
  assign ld_dropped   = dropped(cfg_i.drop_frame, load_i.minutes, load_i.seconds,
                                load_i.frames);

  // Select the outcome; any error keeps the current timecode
  always_comb begin
    nxt_o = cur_i;
    err_o = tc_pkg::ERR_OK;
    case (tc_pkg::tc_kind_e'(kind_i))
      tc_pkg::KIND_FWD: begin
        if (fwd_ovf) err_o = tc_pkg::ERR_HOUR_OVF;
        else         nxt_o = fwd;
      end
      tc_pkg::KIND_BACK: begin
        if (below_zero) err_o = tc_pkg::ERR_BELOW_ZERO;
        else            nxt_o = bwd;
      end
      tc_pkg::KIND_LOAD: begin
        if (ld_range_bad) begin
          err_o = tc_pkg::ERR_LOAD_RANGE;
        end else if (ld_dropped) begin
          err_o = tc_pkg::ERR_LOAD_DROPPED;
        end else begin
          nxt_o         = load_i;
          nxt_o.hours   = ld_hours;
        end
      end
      default: ;
    endcase
  end

endmodule

[src/timecode_counter.sv]
// Top level of the timecode counter: input register, timecode state and result register.
// Timecode counter (hours:minutes:seconds:frames). One word is taken per cycle while
// results are drained. An accepted word sits in the input register and moves into the
// timecode register, which doubles as the result register, when that register is empty
// or its result is being taken; the result then stays on the output until it is taken.
// A full pass of the frame-second-minute-hour cascade runs combinationally between
// the two registers, so a new word may be accepted every cycle as long as results are
// drained; with the result held, one more word waits in the input register and then
// the input stalls. Each word gives exactly one result: the timecode after the word and
// an error code; on any error the timecode is unchanged. The configuration port always
// accepts writes; write it only while the counter is idle.
module timecode_counter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [6:0] load_hours_i,
  input  logic [5:0] load_minutes_i,
  input  logic [5:0] load_seconds_i,
  input  logic [7:0] load_frames_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] hours_o,
  output logic [5:0] minutes_o,
  output logic [5:0] seconds_o,
  output logic [7:0] frames_o,
  output logic [2:0] error_o
);

  tc_pkg::tc_cfg_t  cfg;
  logic             in_vld_q;
  logic [1:0]       kind_q;
  tc_pkg::tc_time_t load_q;
  logic             out_vld_q;
  tc_pkg::tc_time_t time_q;
  tc_pkg::tc_time_t time_d;
  tc_pkg::tc_err_e  err_q;
  tc_pkg::tc_err_e  err_d;
  logic             advance;

  tc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tc_step u_step (
    .cfg_i  (cfg),
    .cur_i  (time_q),
    .kind_i (kind_q),
    .load_i (load_q),
    .nxt_o  (time_d),
    .err_o  (err_d)
  );

  // Move the held word into the result register when there is room
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q         <= kind_i;
      load_q.hours   <= load_hours_i;
      load_q.minutes <= load_minutes_i;
      load_q.seconds <= load_seconds_i;
      load_q.frames  <= load_frames_i;
    end
  end

  // Timecode state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      time_q    <= '0;
      err_q     <= tc_pkg::ERR_OK;
    end else if (advance) begin
      out_vld_q <= 1'b1;
      time_q    <= time_d;
      err_q     <= err_d;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign hours_o     = time_q.hours;
  assign minutes_o   = time_q.minutes;
  assign seconds_o   = time_q.seconds;
  assign frames_o    = time_q.frames;
  assign error_o     = err_q;

`ifndef SYNTHESIS
  // An error leaves the timecode untouched
  a_err_holds_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (err_d != tc_pkg::ERR_OK) |=> time_q == $past(time_q))
    else $error("timecode changed on an error");

  // Minutes and seconds stay in range
  a_min_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (time_q.minutes < tc_pkg::MIN_PER_HOUR) && (time_q.seconds < tc_pkg::SEC_PER_MIN))
    else $error("minutes or seconds out of range");

  // Hours never pass the upper limit
  a_hour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    time_q.hours <= tc_pkg::HOUR_LIMIT)
    else $error("hours out of range");

  // Input stalls only when a word is held and the result is not taken
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && out_vld_q && !out_ready_i)
    else $error("input stalled without cause");

  // A word that moves on always yields a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("result lost");
`endif

endmodule
